// File: hw/rtl/base64_stream_encoder_defines.svh
// Assertion macros shared by the base64 stream encoder RTL.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Check a property on every rising clk_i edge while out of reset.
`define B64E_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("b64e assertion failed");

// Check that a condition never holds on a rising clk_i edge while out of reset.
`define B64E_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("b64e forbidden condition seen");

`endif

// File: hw/rtl/b64e_pkg.sv
// Types, constants and the alphabet lookup shared by the base64 encoder modules.
package b64e_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] UpperBase = 8'h41;  // 'A' - 0
  localparam logic [7:0] LowerBase = 8'h47;  // 'a' - 26
  localparam logic [7:0] DigitOffs = 8'h04;  // 52 - '0', subtracted
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  // Position of the next byte within its three-byte group.
  typedef enum logic [2:0] {
    POS0 = 3'b001,
    POS1 = 3'b010,
    POS2 = 3'b100
  } pos_e;

  // One encoded byte: up to four characters, a count and the end mark.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      cnt_m1;
    logic            last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  function automatic logic [7:0] enc6(logic [5:0] v);
    logic [7:0] r;
    priority if (v < 6'd26) begin
      r = 8'(v) + UpperBase;
    end else if (v < 6'd52) begin
      r = 8'(v) + LowerBase;
    end else if (v < 6'd62) begin
      r = 8'(v) - DigitOffs;
    end else if (v == 6'd62) begin
      r = PlusChar;
    end else begin
      r = SlashChar;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/b64e_front.sv
// Front end: group tracking and splitting of each byte into base64 characters.
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              final_byte_i,
  output b64e_pkg::entry_t  entry_o,
  output logic              pos_zero_o
);

  b64e_pkg::pos_e pos_q, pos_d;
  logic [3:0]     carry_q, carry_d;

  always_comb begin
    entry_o.chars  = {4{b64e_pkg::PadChar}};
    entry_o.cnt_m1 = 2'd0;
    entry_o.last   = final_byte_i;
    pos_d          = pos_q;
    carry_d        = carry_q;
    unique case (pos_q)
      b64e_pkg::POS1: begin
        entry_o.chars[0] = b64e_pkg::enc6({carry_q[1:0], data_byte_i[7:4]});
        if (final_byte_i) begin
          entry_o.chars[1] = b64e_pkg::enc6({data_byte_i[3:0], 2'b00});
          entry_o.cnt_m1   = 2'd2;
        end
        pos_d   = b64e_pkg::POS2;
        carry_d = data_byte_i[3:0];
      end
      b64e_pkg::POS2: begin
        entry_o.chars[0] = b64e_pkg::enc6({carry_q, data_byte_i[7:6]});
        entry_o.chars[1] = b64e_pkg::enc6(data_byte_i[5:0]);
        entry_o.cnt_m1   = 2'd1;
        pos_d            = b64e_pkg::POS0;
        carry_d          = 4'd0;
      end
      default: begin
        entry_o.chars[0] = b64e_pkg::enc6(data_byte_i[7:2]);
        if (final_byte_i) begin
          entry_o.chars[1] = b64e_pkg::enc6({data_byte_i[1:0], 4'b0000});
          entry_o.cnt_m1   = 2'd3;
        end
        pos_d   = b64e_pkg::POS1;
        carry_d = {2'b00, data_byte_i[1:0]};
      end
    endcase
    // Restart the group at the end of a message.
    if (final_byte_i) begin
      pos_d   = b64e_pkg::POS0;
      carry_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= b64e_pkg::POS0;
      carry_q <= 4'd0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      carry_q <= carry_d;
    end
  end

  assign pos_zero_o = (pos_q == b64e_pkg::POS0);

endmodule

// File: hw/rtl/b64e_queue.sv
// Short entry queue between the front end and the character output stage.
module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64e_pkg::entry_t     push_entry_i,
  input  logic                 pop_i,
  output b64e_pkg::entry_t     head_o,
  output b64e_pkg::q_status_t  status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

  b64e_pkg::entry_t slots_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o            = slots_q[rptr_q];
  assign status_o.full     = (cnt_q == CW'(DEPTH));
  assign status_o.nonempty = (cnt_q != '0);

endmodule

// File: hw/rtl/b64e_back.sv
// Back end: hands out the characters of each entry one per transfer.
module b64e_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b64e_pkg::entry_t     head_i,
  input  b64e_pkg::q_status_t  q_status_i,
  output logic                 load_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [7:0]           out_char_o,
  output logic                 out_last_o
);

  b64e_pkg::entry_t cur_q;
  logic [1:0]       idx_q;
  logic             valid_q;
  logic             at_end;

  assign at_end = (idx_q == cur_q.cnt_m1);
  // Refill when idle or when the final character of the entry transfers.
  assign load_o = q_status_i.nonempty && (!valid_q || (pop_i && at_end));

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load_o) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (valid_q && pop_i) begin
      if (at_end) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assign empty_o    = !valid_q;
  assign out_char_o = cur_q.chars[idx_q];
  assign out_last_o = cur_q.last && at_end;

endmodule

// File: hw/rtl/base64_stream_encoder.sv
// A transferred byte passes through the entry queue into the output register.
// Throughput: one character per cycle from the single output register while pop_i
// is high; bytes are taken every cycle while the queue has room, three bytes per four
// characters sustained. A final byte adds up to two padding characters at that rate.
// Reset (rst_ni low, asynchronous): group position, carry bits, queue and output
// stage return to empty; no character is pending afterwards.
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  b64e_pkg::entry_t    fe_entry;
  b64e_pkg::entry_t    q_head;
  b64e_pkg::q_status_t q_status;
  logic                in_xfer;
  logic                q_pop;
  logic                pos_zero;

  // A byte transfers when pushed into a queue with room.
  assign full_o  = q_status.full;
  assign in_xfer = push_i && !q_status.full;

  // Front end: split each byte into its characters and track the group.
  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_xfer),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .entry_o      (fe_entry),
    .pos_zero_o   (pos_zero)
  );

  // Queue decouples byte intake from the character stream.
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_xfer),
    .push_entry_i (fe_entry),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .status_o     (q_status)
  );

  // Back end: drain each entry one character per transfer.
  b64e_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .q_status_i (q_status),
    .load_o     (q_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o)
  );

  // The output stage never pulls from an empty queue.
  `B64E_ASSERT_NEVER(a_load_from_empty, q_pop && !q_status.nonempty)
  // A final byte always restarts the next group at position zero.
  `B64E_ASSERT(a_final_resets_pos, in_xfer && final_byte_i |=> pos_zero)
  // While nothing can enter the queue, a full queue cannot both refill and stay full.
  `B64E_ASSERT(a_full_drains, q_status.full && q_pop |=> !q_status.full)

endmodule
